// ===== sv/pcc_pkg.sv =====
// Package for the palette color converter: shared types, constants and the microcode ROM.
// Used by the channel interfaces, the sequencer, the datapath and the top level.
// Has no dependencies of its own.
package pcc_pkg;

    // Opcodes of an input word.
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_FILTER_ENABLE = 2'd0;
    localparam cfg_index_t CFG_YUV_MODE      = 2'd1;

    // Longest run of results that one refresh may produce.
    localparam int RESULT_LIMIT = 64;

    // Fixed-point scaling of the correction matrix and of the YUV transform.
    localparam int FILT_SHIFT = 8;
    localparam int YUV_SHIFT  = 10;

    // Accumulator wide enough for 255 times the largest row sum of coefficients.
    localparam int ACC_W = 20;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [10:0] coef_t;

    // Micro-operations of the datapath.
    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_READ,
        UOP_LOAD,
        UOP_MAC,
        UOP_FILT_END,
        UOP_YUV_END,
        UOP_EMIT
    } uop_t;

    // Channel that feeds the three multiply-accumulate lanes.
    typedef enum logic [1:0] {
        CH_R,
        CH_G,
        CH_B
    } chsel_t;

    // Jump conditions; a true condition loads the target step.
    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_START,
        COND_UNCHANGED,
        COND_NO_FILTER,
        COND_NO_YUV,
        COND_MORE
    } cond_t;

    typedef logic [3:0] step_t;

    // Step addresses of the microprogram.
    localparam step_t STEP_WAIT  = 4'd0;
    localparam step_t STEP_READ  = 4'd1;
    localparam step_t STEP_LOAD  = 4'd2;
    localparam step_t STEP_F0    = 4'd3;
    localparam step_t STEP_F1    = 4'd4;
    localparam step_t STEP_F2    = 4'd5;
    localparam step_t STEP_FEND  = 4'd6;
    localparam step_t STEP_Y0    = 4'd7;
    localparam step_t STEP_Y1    = 4'd8;
    localparam step_t STEP_Y2    = 4'd9;
    localparam step_t STEP_YEND  = 4'd10;
    localparam step_t STEP_EMIT  = 4'd11;
    localparam step_t STEP_LAST  = STEP_EMIT;

    // One control word of the microprogram.
    typedef struct packed {
        uop_t        uop;
        chsel_t      src;
        logic        clr;
        coef_t       coef_a;
        coef_t       coef_b;
        coef_t       coef_c;
        logic [7:0]  off_a;
        logic [7:0]  off_b;
        logic [7:0]  off_c;
        cond_t       cond;
        step_t       target;
    } ctrl_word_t;

    // Status the datapath reports to the sequencer.
    typedef struct packed {
        logic start;
        logic unchanged;
        logic more;
        logic out_busy;
        logic filter_en;
        logic yuv_en;
    } status_t;

    // Microcode ROM. Each lane a, b, c accumulates one output channel.
    function automatic ctrl_word_t ucode_rom(input step_t addr);
        ctrl_word_t w;
        w = '0;
        w.uop = UOP_WAIT;
        w.src = CH_R;
        w.cond = COND_NONE;
        w.target = STEP_WAIT;
        case (addr)
            STEP_WAIT:
            begin
                w.uop = UOP_WAIT;
                w.cond = COND_NO_START;
                w.target = STEP_WAIT;
            end
            STEP_READ:
            begin
                w.uop = UOP_READ;
            end
            STEP_LOAD:
            begin
                w.uop = UOP_LOAD;
                w.cond = COND_UNCHANGED;
                w.target = STEP_WAIT;
            end
            STEP_F0:
            begin
                w.uop = UOP_MAC;
                w.src = CH_R;
                w.clr = 1'b1;
                w.coef_a = 11'sd195;
                w.coef_b = 11'sd25;
                w.coef_c = 11'sd25;
                w.cond = COND_NO_FILTER;
                w.target = STEP_Y0;
            end
            STEP_F1:
            begin
                w.uop = UOP_MAC;
                w.src = CH_G;
                w.coef_a = 11'sd25;
                w.coef_b = 11'sd170;
                w.coef_c = 11'sd60;
            end
            STEP_F2:
            begin
                w.uop = UOP_MAC;
                w.src = CH_B;
                w.coef_a = 11'sd0;
                w.coef_b = 11'sd25;
                w.coef_c = 11'sd125;
            end
            STEP_FEND:
            begin
                w.uop = UOP_FILT_END;
                w.off_a = 8'd35;
                w.off_b = 8'd35;
                w.off_c = 8'd40;
            end
            STEP_Y0:
            begin
                w.uop = UOP_MAC;
                w.src = CH_R;
                w.clr = 1'b1;
                w.coef_a = 11'sd263;
                w.coef_b = 11'sd450;
                w.coef_c = -11'sd152;
                w.cond = COND_NO_YUV;
                w.target = STEP_EMIT;
            end
            STEP_Y1:
            begin
                w.uop = UOP_MAC;
                w.src = CH_G;
                w.coef_a = 11'sd516;
                w.coef_b = -11'sd377;
                w.coef_c = -11'sd298;
            end
            STEP_Y2:
            begin
                w.uop = UOP_MAC;
                w.src = CH_B;
                w.coef_a = 11'sd100;
                w.coef_b = -11'sd73;
                w.coef_c = 11'sd450;
            end
            STEP_YEND:
            begin
                w.uop = UOP_YUV_END;
                w.off_a = 8'd16;
                w.off_b = 8'd128;
                w.off_c = 8'd128;
            end
            STEP_EMIT:
            begin
                w.uop = UOP_EMIT;
                w.cond = COND_MORE;
                w.target = STEP_READ;
            end
            default:
            begin
                w.uop = UOP_WAIT;
                w.cond = COND_NONE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/pcc_if.sv =====
// Channel interfaces of the palette color converter: command, result and configuration.
// Each carries valid, ready and its payload; depends on pcc_pkg.
interface pcc_cmd_if;
    import pcc_pkg::*;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [6:0] byte_index;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output byte_index, output data_byte,
                    input ready);
    modport sink (input valid, input opcode, input byte_index, input data_byte,
                  output ready);
endinterface

interface pcc_rsp_if;
    import pcc_pkg::*;
    logic       valid;
    logic       ready;
    logic [5:0] color_index;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
    logic       last;

    modport source (output valid, output color_index, output chan_a, output chan_b,
                    output chan_c, output last, input ready);
    modport sink (input valid, input color_index, input chan_a, input chan_b,
                  input chan_c, input last, output ready);
endinterface

interface pcc_cfg_if;
    import pcc_pkg::*;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    logic       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/pcc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/pcc_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on pcc_pkg for the control word, status struct and ROM contents.
module pcc_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  pcc_pkg::status_t    st,
    output pcc_pkg::ctrl_word_t ctrl
);
    import pcc_pkg::*;

    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t cw;
    logic       jump;
    logic       hold;

    // Control word of the current step.
    assign cw = ucode_rom(step_reg);
    assign ctrl = cw;

    // Jump condition selected by the control word.
    always_comb
    begin
        case (cw.cond)
            COND_NONE:      jump = 1'b0;
            COND_NO_START:  jump = !st.start;
            COND_UNCHANGED: jump = st.unchanged;
            COND_NO_FILTER: jump = !st.filter_en;
            COND_NO_YUV:    jump = !st.yuv_en;
            COND_MORE:      jump = st.more;
            default:        jump = 1'b0;
        endcase
    end

    // The emit step waits while the result register is still occupied.
    assign hold = (cw.uop == UOP_EMIT) && st.out_busy;

    // Next step: hold, jump, or fall through with wrap to the wait step.
    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (jump)
        begin
            step_next = cw.target;
        end
        else if (step_reg == STEP_LAST)
        begin
            step_next = STEP_WAIT;
        end
        else
        begin
            step_next = step_reg + 4'd1;
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // The program never leaves the populated part of the ROM.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("sequencer step outside the microprogram");

    // An unchanged palette byte ends the item without a result.
    a_unchanged_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.uop == UOP_LOAD) && st.unchanged |=> (step_reg == STEP_WAIT))
        else $error("unchanged write did not return to the wait step");

endmodule

// ===== sv/pcc_datapath.sv =====
// Datapath of the palette color converter: palette RAMs, channel registers,
// three multiply-accumulate lanes, configuration registers and the result register.
// Depends on pcc_pkg, pcc_if and pcc_ram.
module pcc_datapath #(
    parameter int PALETTE_COLORS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pcc_pkg::ctrl_word_t ctrl,
    output pcc_pkg::status_t    st,
    pcc_cmd_if.sink             cmd,
    pcc_rsp_if.source           rsp,
    pcc_cfg_if.sink             cfg
);
    import pcc_pkg::*;

    localparam int AW = (PALETTE_COLORS > 1) ? $clog2(PALETTE_COLORS) : 1;
    localparam int REFRESH_COUNT =
        (PALETTE_COLORS < RESULT_LIMIT) ? PALETTE_COLORS : RESULT_LIMIT;
    localparam logic [AW-1:0] LAST_N = AW'(REFRESH_COUNT - 1);
    localparam logic [9:0] BYTE_LIMIT = 10'(2 * PALETTE_COLORS);

    // Widen a 5-bit channel to 8 bits by repeating its top bits.
    function automatic logic [7:0] expand5(input logic [4:0] x);
        return {x, x[4:2]};
    endfunction

    // Clamp a signed value to 0..255.
    function automatic logic [7:0] clamp8(input acc_t v);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > acc_t'(255))
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic filter_en_reg;
    logic yuv_en_reg;

    // Latched command word and refresh counter.
    logic          opcode_reg;
    logic [AW-1:0] row_reg;
    logic          hi_sel_reg;
    logic [7:0]    data_reg;
    logic [AW-1:0] n_reg;

    // Row valid bits stand in for clearing the palette at reset.
    logic [PALETTE_COLORS-1:0] valid_reg;
    logic                      rd_valid_reg;

    // Palette RAM ports.
    logic [AW-1:0] rd_addr;
    logic [7:0]    lo_rdata;
    logic [7:0]    hi_rdata;
    logic          ram_we;

    // Channel, accumulator and result registers.
    logic [7:0] rgb_reg [3];
    logic [7:0] yuv_reg [3];
    acc_t       acc_reg [3];
    logic [5:0] cidx_reg;

    logic       out_valid_reg;
    logic [5:0] out_cidx_reg;
    logic [7:0] out_chan_reg [3];
    logic       out_last_reg;

    logic        cmd_acc;
    logic        start_ok;
    logic [9:0]  row_wide;
    logic [7:0]  old_lo;
    logic [7:0]  old_hi;
    logic [7:0]  new_lo;
    logic [7:0]  new_hi;
    logic [14:0] color;
    logic        unchanged;
    logic        out_busy;
    logic        emit_fire;
    logic        more;
    logic [7:0]  mac_x;
    logic signed [8:0] mac_x_s;
    coef_t       lane_coef [3];
    logic [7:0]  lane_off [3];
    acc_t        prod [3];
    acc_t        fsum [3];
    acc_t        ysum [3];

    // Configuration port: always ready, writes beyond the list are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_en_reg <= 1'b0;
            yuv_en_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_FILTER_ENABLE)
            begin
                filter_en_reg <= cfg.data;
            end
            if (cfg.index == CFG_YUV_MODE)
            begin
                yuv_en_reg <= cfg.data;
            end
        end
    end

    // Command acceptance; a write beyond the palette starts nothing.
    assign cmd.ready = (ctrl.uop == UOP_WAIT);
    assign cmd_acc = cmd.valid && cmd.ready;
    assign start_ok = cmd_acc &&
        ((cmd.opcode == OP_REFRESH) || ({3'b000, cmd.byte_index} < BYTE_LIMIT));
    assign row_wide = {4'b0000, cmd.byte_index[6:1]};

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            opcode_reg <= cmd.opcode;
            row_reg <= row_wide[AW-1:0];
            hi_sel_reg <= cmd.byte_index[0];
            data_reg <= cmd.data_byte;
        end
    end

    // Refresh counter: cleared on acceptance, stepped after each emitted color of a refresh but the last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else if (cmd_acc)
        begin
            n_reg <= '0;
        end
        else if (emit_fire && more)
        begin
            n_reg <= n_reg + AW'(1);
        end
    end

    assign more = (opcode_reg == OP_REFRESH) && (n_reg != LAST_N);

    // Palette storage: low and high bytes of each color in two RAMs.
    assign rd_addr = (opcode_reg == OP_REFRESH) ? n_reg : row_reg;

    pcc_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_COLORS)
    ) u_lo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (new_lo),
        .raddr (rd_addr),
        .rdata (lo_rdata)
    );

    pcc_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_COLORS)
    ) u_hi_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (new_hi),
        .raddr (rd_addr),
        .rdata (hi_rdata)
    );

    // A row never written reads as zero.
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_reg[rd_addr];
    end

    assign old_lo = rd_valid_reg ? lo_rdata : 8'd0;
    assign old_hi = rd_valid_reg ? hi_rdata : 8'd0;

    // Merge the written byte into the stored color.
    always_comb
    begin
        new_lo = old_lo;
        new_hi = old_hi;
        if (opcode_reg == OP_WRITE)
        begin
            if (hi_sel_reg)
            begin
                new_hi = data_reg;
            end
            else
            begin
                new_lo = data_reg;
            end
        end
    end

    assign unchanged = (opcode_reg == OP_WRITE) &&
        ((hi_sel_reg ? old_hi : old_lo) == data_reg);
    assign ram_we = (ctrl.uop == UOP_LOAD) && (opcode_reg == OP_WRITE) && !unchanged;
    assign color = {new_hi[6:0], new_lo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[row_reg] <= 1'b1;
        end
    end

    // Multiply-accumulate lanes share one channel operand per step.
    always_comb
    begin
        case (ctrl.src)
            CH_R:    mac_x = rgb_reg[0];
            CH_G:    mac_x = rgb_reg[1];
            CH_B:    mac_x = rgb_reg[2];
            default: mac_x = 8'd0;
        endcase
    end

    assign mac_x_s = $signed({1'b0, mac_x});
    assign lane_coef[0] = ctrl.coef_a;
    assign lane_coef[1] = ctrl.coef_b;
    assign lane_coef[2] = ctrl.coef_c;
    assign lane_off[0] = ctrl.off_a;
    assign lane_off[1] = ctrl.off_b;
    assign lane_off[2] = ctrl.off_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = acc_t'(mac_x_s) * acc_t'($signed(lane_coef[i]));
            fsum[i] = (acc_reg[i] >>> FILT_SHIFT) + acc_t'(lane_off[i]);
            ysum[i] = (acc_reg[i] >>> YUV_SHIFT) + acc_t'(lane_off[i]);
        end
    end

    // Accumulators, channel registers and YUV registers.
    always_ff @(posedge clk)
    begin
        case (ctrl.uop)
            UOP_LOAD:
            begin
                rgb_reg[0] <= expand5(color[4:0]);
                rgb_reg[1] <= expand5(color[9:5]);
                rgb_reg[2] <= expand5(color[14:10]);
                cidx_reg <= 6'(rd_addr);
            end
            UOP_MAC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc_reg[i] <= ctrl.clr ? prod[i] : acc_reg[i] + prod[i];
                end
            end
            UOP_FILT_END:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rgb_reg[i] <= fsum[i][7:0];
                end
            end
            UOP_YUV_END:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    yuv_reg[i] <= clamp8(ysum[i]);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register decouples the sequencer from the result consumer.
    assign out_busy = out_valid_reg && !rsp.ready;
    assign emit_fire = (ctrl.uop == UOP_EMIT) && !out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_cidx_reg <= cidx_reg;
            for (int i = 0; i < 3; i++)
            begin
                out_chan_reg[i] <= yuv_en_reg ? yuv_reg[i] : rgb_reg[i];
            end
            out_last_reg <= (opcode_reg == OP_WRITE) || (n_reg == LAST_N);
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.color_index = out_cidx_reg;
    assign rsp.chan_a = out_chan_reg[0];
    assign rsp.chan_b = out_chan_reg[1];
    assign rsp.chan_c = out_chan_reg[2];
    assign rsp.last = out_last_reg;

    // Status toward the sequencer.
    assign st.start = start_ok;
    assign st.unchanged = unchanged;
    assign st.more = more;
    assign st.out_busy = out_busy;
    assign st.filter_en = filter_en_reg;
    assign st.yuv_en = yuv_en_reg;

    // The refresh counter never passes the last color of a run.
    a_refresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= LAST_N)
        else $error("refresh counter beyond the last color");

    // A palette write marks its row as holding data.
    a_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(row_reg)])
        else $error("written palette row not marked valid");

    // A write produces a single result, so it is always marked last.
    a_write_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && (opcode_reg == OP_WRITE) |=> (out_valid_reg && out_last_reg))
        else $error("write result not marked last");

endmodule

// ===== sv/palette_color_convert_top.sv =====
// Top level of the palette color converter: sequencer plus datapath.
// An in-range write that changes a byte gives its word after the steps of the microprogram:
// read, load, optional color correction, optional YUV transform, emit.
// A write beyond the palette leaves the sequencer in the wait step, an unchanged byte ends after the load step;
// a refresh emits min(PALETTE_COLORS, 64) words. A new command is taken only in the wait step.
// Reset clears the configuration and the palette (row valid bits, no clearing pass).
module palette_color_convert_top #(
    parameter int PALETTE_COLORS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    pcc_cmd_if.sink    cmd,
    pcc_rsp_if.source  rsp,
    pcc_cfg_if.sink    cfg
);
    import pcc_pkg::*;

    ctrl_word_t ctrl;
    status_t    st;

    // Microcode sequencer.
    pcc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctrl  (ctrl)
    );

    // Palette storage and arithmetic.
    pcc_datapath #(
        .PALETTE_COLORS (PALETTE_COLORS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .st    (st),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg)
    );

endmodule
